// ----- hw/rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, codes and defaults for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int MaxSetBitsDef = 6;
  localparam int MaxWaysDef    = 8;
  localparam int AddrWidthDef  = 64;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  localparam logic [4:0] BlockBitsMax = 5'd16;

  localparam logic [2:0] SetBitsRst   = 3'd4;
  localparam logic [3:0] WaysInUseRst = 4'd1;
  localparam logic [4:0] BlockBitsRst = 5'd4;

  localparam logic [CfgIdxW-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_IFETCH = 2'd3;

  localparam logic [1:0] OUT_HIT        = 2'd0;
  localparam logic [1:0] OUT_MISS_FILL  = 2'd1;
  localparam logic [1:0] OUT_MISS_EVICT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        second_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } out_t;

  typedef struct packed {
    logic       hit;
    logic       evict;
    logic [1:0] outcome;
  } acc_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sacl_mem.sv -----
// ----------------------------------------------------------------------------
// sacl_mem
// Set row memory: one read and one write port, registered read data with
// write-to-read forwarding, and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_mem #(
  parameter int DATA_W = 8,
  parameter int IDX_W  = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_idx,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   ready
);

  localparam int Depth = 2 ** IDX_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rd_data_r;
  logic [IDX_W:0]    clr_cnt_r;
  logic              w_en;
  logic [IDX_W-1:0]  w_idx;
  logic [DATA_W-1:0] w_data;

  assign ready  = clr_cnt_r[IDX_W];
  assign w_en   = !ready || wr_en;
  assign w_idx  = ready ? wr_idx : clr_cnt_r[IDX_W-1:0];
  assign w_data = ready ? wr_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!ready) begin
      clr_cnt_r <= clr_cnt_r + (IDX_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_idx] <= w_data;
    end
    if (rd_en) begin
      rd_data_r <= (w_en && (w_idx == rd_idx)) ? w_data : mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sacl_update.sv -----
// ----------------------------------------------------------------------------
// sacl_update
// Lookup and LRU update of one set row: hit search, free way search,
// victim choice and rank aging.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_update #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  parameter int RANK_W     = 3,
  parameter int WAYS_W     = 4
) (
  input  wire logic [MAX_WAYS-1:0]                 vld_i,
  input  wire logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_i,
  input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_i,
  input  wire logic [ADDR_WIDTH-1:0]               tag,
  input  wire logic [WAYS_W-1:0]                   ways,
  output logic      [MAX_WAYS-1:0]                 vld_o,
  output logic      [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_o,
  output logic      [MAX_WAYS-1:0][RANK_W-1:0]     rank_o,
  output sacl_pkg::acc_stat_t                      stat
);

  localparam logic [RANK_W-1:0] RankMax = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic                hit;
  logic                free_any;
  logic [RANK_W-1:0]   hit_way;
  logic [RANK_W-1:0]   free_way;
  logic [RANK_W-1:0]   victim;
  logic [RANK_W-1:0]   best;
  logic [RANK_W-1:0]   way_sel;
  logic [RANK_W-1:0]   old_rank;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j]   = (j < int'(ways));
      hit_vec[j]  = in_use[j] && vld_i[j] && (tag_i[j] == tag);
      free_vec[j] = in_use[j] && !vld_i[j];
    end
    hit      = |hit_vec;
    free_any = |free_vec;

    hit_way  = '0;
    free_way = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_way = RANK_W'(j);
      end
      if (free_vec[j]) begin
        free_way = RANK_W'(j);
      end
    end

    victim = '0;
    best   = rank_i[0];
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && (rank_i[j] > best)) begin
        best   = rank_i[j];
        victim = RANK_W'(j);
      end
    end

    way_sel  = hit ? hit_way : (free_any ? free_way : victim);
    old_rank = rank_i[hit_way];
  end

  always_comb begin
    vld_o  = vld_i;
    tag_o  = tag_i;
    rank_o = rank_i;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (RANK_W'(j) == way_sel) begin
        rank_o[j] = '0;
        if (!hit) begin
          vld_o[j] = 1'b1;
          tag_o[j] = tag;
        end
      end else if (in_use[j] && vld_i[j] && (!hit || (rank_i[j] < old_rank)) &&
                   (rank_i[j] < RankMax)) begin
        rank_o[j] = rank_i[j] + RANK_W'(1);
      end
    end
  end

  always_comb begin
    stat.hit   = hit;
    stat.evict = !hit && !free_any;
    if (hit) begin
      stat.outcome = sacl_pkg::OUT_HIT;
    end else if (free_any) begin
      stat.outcome = sacl_pkg::OUT_MISS_FILL;
    end else begin
      stat.outcome = sacl_pkg::OUT_MISS_EVICT;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/set_assoc_cache_lru_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache model with true LRU replacement and running counts.
// ----------------------------------------------------------------------------
// Each load, store or modify is a read-modify-write of its set row: on
// acceptance the whole set row (valid bits, tags and LRU ranks of all ways)
// is read into the registered read data of the row memory; in the access
// state, once the result register is free, the row is updated, written back
// and the result register loaded, while the next item may already be
// accepted. An instruction fetch is accepted without a row access and gives
// no result. After reset a clearing pass zeroes all 2**MAX_SET_BITS rows (64 by
// default) of the memory, and no item is taken until it ends; configuration writes are taken at any time.
`default_nettype none

module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::MaxSetBitsDef,
  parameter int MAX_WAYS     = sacl_pkg::MaxWaysDef,
  parameter int ADDR_WIDTH   = sacl_pkg::AddrWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire sacl_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output sacl_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [sacl_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [sacl_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + RANK_W);

  sacl_pkg::state_t state_r, state_nxt;

  logic [2:0] set_bits_r;
  logic [3:0] ways_in_use_r;
  logic [4:0] block_bits_r;

  logic                  in_acc;
  logic                  start;
  logic                  out_free;
  logic                  wb_en;
  logic                  mem_ready;

  logic [ADDR_WIDTH-1:0] addr_m;
  logic [3:0]            s_eff;
  logic [4:0]            b_eff;
  logic [WAYS_W-1:0]     ways_eff;
  logic [ADDR_WIDTH-1:0] set_sh;
  logic [IDX_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag_nxt;

  logic [1:0]            cmd_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [IDX_W-1:0]      set_r;
  logic [WAYS_W-1:0]     ways_r;

  logic [ROW_W-1:0]                 rd_row;
  logic [ROW_W-1:0]                 wr_row;
  logic [MAX_WAYS-1:0]              row_vld, new_vld;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] row_tag, new_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0]  row_rank, new_rank;
  sacl_pkg::acc_stat_t              stat;

  logic           is_mod;
  logic [31:0]    hits_r, misses_r, evicts_r;
  logic [31:0]    hits_nxt, misses_nxt, evicts_nxt;
  logic           out_valid_r;
  sacl_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= sacl_pkg::SetBitsRst;
      ways_in_use_r <= sacl_pkg::WaysInUseRst;
      block_bits_r  <= sacl_pkg::BlockBitsRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacl_pkg::CFG_SET_BITS:   set_bits_r    <= cfg_wdata[2:0];
        sacl_pkg::CFG_WAYS:       ways_in_use_r <= cfg_wdata[3:0];
        sacl_pkg::CFG_BLOCK_BITS: block_bits_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    addr_m = in_data.address[ADDR_WIDTH-1:0];
    s_eff  = (int'(set_bits_r) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_r};
    b_eff  = (block_bits_r > sacl_pkg::BlockBitsMax) ? sacl_pkg::BlockBitsMax : block_bits_r;
    if (ways_in_use_r == 4'd0) begin
      ways_eff = WAYS_W'(1);
    end else if (int'(ways_in_use_r) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(ways_in_use_r);
    end
    set_sh  = addr_m >> b_eff;
    set_idx = set_sh[IDX_W-1:0] & ~({IDX_W{1'b1}} << s_eff);
    tag_nxt = addr_m >> (6'(b_eff) + 6'(s_eff));
  end

  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && (in_data.command != sacl_pkg::CMD_IFETCH);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        if (mem_ready) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sacl_pkg::ST_ACCESS;
        end
      end
      sacl_pkg::ST_ACCESS: begin
        if (out_free) begin
          state_nxt = start ? sacl_pkg::ST_ACCESS : sacl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    wb_en    = 1'b0;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: ;
      sacl_pkg::ST_IDLE: in_ready = 1'b1;
      sacl_pkg::ST_ACCESS: begin
        in_ready = out_free;
        wb_en    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r  <= in_data.command;
      tag_r  <= tag_nxt;
      set_r  <= set_idx;
      ways_r <= ways_eff;
    end
  end

  sacl_mem #(
    .DATA_W (ROW_W),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (start),
    .rd_idx  (set_idx),
    .rd_data (rd_row),
    .wr_en   (wb_en),
    .wr_idx  (set_r),
    .wr_data (wr_row),
    .ready   (mem_ready)
  );

  assign {row_vld, row_tag, row_rank} = rd_row;
  assign wr_row = {new_vld, new_tag, new_rank};

  sacl_update #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .RANK_W     (RANK_W),
    .WAYS_W     (WAYS_W)
  ) u_update (
    .vld_i  (row_vld),
    .tag_i  (row_tag),
    .rank_i (row_rank),
    .tag    (tag_r),
    .ways   (ways_r),
    .vld_o  (new_vld),
    .tag_o  (new_tag),
    .rank_o (new_rank),
    .stat   (stat)
  );

  // A modify's second access always finds the line just made most recent.
  assign is_mod     = (cmd_r == sacl_pkg::CMD_MODIFY);
  assign hits_nxt   = hits_r + 32'(stat.hit) + 32'(is_mod);
  assign misses_nxt = misses_r + 32'(!stat.hit);
  assign evicts_nxt = evicts_r + 32'(stat.evict);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (wb_en) begin
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      out_data_r.outcome     <= stat.outcome;
      out_data_r.second_hit  <= is_mod;
      out_data_r.hit_total   <= hits_nxt;
      out_data_r.miss_total  <= misses_nxt;
      out_data_r.evict_total <= evicts_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sacl_checker.sv -----
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache model: reset behavior, result beat holding,
// legal outcome codes and the ready rule after a memory access starts.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire sacl_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire sacl_pkg::out_t out_data
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_outcome_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome == sacl_pkg::OUT_HIT) ||
                  (out_data.outcome == sacl_pkg::OUT_MISS_FILL) ||
                  (out_data.outcome == sacl_pkg::OUT_MISS_EVICT))
    else $error("illegal outcome code");

  a_ready_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command != sacl_pkg::CMD_IFETCH)
      |=> in_ready == (!out_valid || out_ready))
    else $error("ready does not follow result register space during access");

endmodule

bind set_assoc_cache_lru_sim sacl_checker u_sacl_checker (.*);

`default_nettype wire
